// ===== sv/keyed_ring_table_unit_assert.svh =====
// assertion macros used by the keyed ring table engine
`ifndef KEYED_RING_TABLE_UNIT_ASSERT_SVH
`define KEYED_RING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk_i outside reset
`define KRT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define KRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/krt_pkg.sv =====
// types and constants of the keyed ring table
package krt_pkg;

  localparam int KeyW       = 32;
  localparam int TimeW      = 32;
  localparam int PayloadW   = 64;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } krt_cmd_e;

  typedef enum logic [2:0] {
    RES_UPDATED   = 3'd0,
    RES_INSERTED  = 3'd1,
    RES_EVICTED   = 3'd2,
    RES_REMOVED   = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_EMPTY     = 3'd5
  } krt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_COPY,
    S_MISS,
    S_FILL,
    S_EMIT
  } krt_state_e;

  typedef struct packed {
    krt_cmd_e          cmd;
    logic [KeyW-1:0]   key;
    logic [TimeW-1:0]  stamp;
  } krt_hdr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } krt_qstat_t;

endpackage

// ===== sv/krt_front.sv =====
// front stage: takes input transfers, decodes the command and feeds the queue
module krt_front #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [krt_pkg::KeyW-1:0]   entry_key_i,
  input  logic [krt_pkg::PayloadW-1:0] entry_payload_i,
  input  logic [krt_pkg::TimeW-1:0]  entry_time_i,
  input  krt_pkg::krt_qstat_t        q_stat_i,
  output logic                       push_o,
  output krt_pkg::krt_hdr_t          push_hdr_o,
  output logic [PAYLOAD_BITS-1:0]    push_payload_o
);
  import krt_pkg::*;

  logic                    hold_vld_q, hold_vld_d;
  krt_hdr_t                hdr_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    accept;

  // handshake: stall only while the held item cannot move on
  always_comb begin
    push_o     = hold_vld_q && !q_stat_i.full;
    in_stall_o = hold_vld_q && q_stat_i.full;
    accept     = in_valid_i && !in_stall_o;
    hold_vld_d = accept || (hold_vld_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
    end
  end

  // decode and capture, payload cut to the stored width
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q.cmd   <= krt_cmd_e'(command_i);
      hdr_q.key   <= entry_key_i;
      hdr_q.stamp <= entry_time_i;
      pay_q       <= entry_payload_i[PAYLOAD_BITS-1:0];
    end
  end

  assign push_hdr_o     = hdr_q;
  assign push_payload_o = pay_q;

endmodule

// ===== sv/krt_queue.sv =====
// short queue between the front stage and the table engine
module krt_queue #(
  parameter int W = 97
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        push_data_i,
  input  logic                pop_i,
  output logic [W-1:0]        pop_data_o,
  output krt_pkg::krt_qstat_t stat_o
);
  import krt_pkg::*;

  logic [W-1:0]     mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;
  logic             do_push, do_pop;

  // pointer and fill bookkeeping
  always_comb begin
    stat_o.empty = (fill_q == '0);
    stat_o.full  = (fill_q == (QPtrW+1)'(QueueDepth));
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    wr_ptr_d     = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d       = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

// ===== sv/krt_engine.sv =====
// table engine: window scan, slot memories, update sequencing and result register
`include "keyed_ring_table_unit_assert.svh"

module krt_engine #(
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  krt_pkg::krt_qstat_t        q_stat_i,
  output logic                       pop_o,
  input  krt_pkg::krt_hdr_t          pop_hdr_i,
  input  logic [PAYLOAD_BITS-1:0]    pop_payload_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output krt_pkg::krt_status_e       status_o,
  output logic [$clog2(DEPTH)-1:0]   slot_index_o,
  output logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  output logic [krt_pkg::KeyW-1:0]   evicted_key_o
);
  import krt_pkg::*;

  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  // slot memories
  logic [KeyW-1:0]         key_mem  [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];
  logic [TimeW-1:0]        time_mem [DEPTH];

  logic [KeyW-1:0]         key_rd_q;
  logic [PAYLOAD_BITS-1:0] pay_rd_q;
  logic [TimeW-1:0]        time_rd_q;

  krt_state_e              st_q, st_d;
  logic [IDXW-1:0]         cur_q, cur_d;
  logic [CNTW-1:0]         cnt_q, cnt_d;
  krt_hdr_t                op_hdr_q;
  logic [PAYLOAD_BITS-1:0] op_pay_q;
  logic                    op_ld;
  logic [CNTW-1:0]         scan_ofs_q, scan_ofs_d;
  logic [IDXW-1:0]         scan_slot_q, scan_slot_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    rd_last_q, rd_last_d;
  logic [IDXW-1:0]         rd_slot_q, rd_slot_d;
  logic [IDXW-1:0]         hit_q, hit_d;
  krt_status_e             res_status_q, res_status_d;
  logic [IDXW-1:0]         res_slot_q, res_slot_d;
  logic [KeyW-1:0]         res_evict_q, res_evict_d;

  logic                    out_vld_q, out_vld_d;
  krt_status_e             out_status_q;
  logic [IDXW-1:0]         out_slot_q;
  logic [CNTW-1:0]         out_cnt_q;
  logic [KeyW-1:0]         out_evict_q;
  logic                    out_ld;

  logic [IDXW-1:0]         rd_addr;
  logic                    key_we, pt_we;
  logic [IDXW-1:0]         wr_addr;
  logic [KeyW-1:0]         wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;
  logic [TimeW-1:0]        wr_time;

  logic [CNTW:0]           start_sum;
  logic [IDXW-1:0]         start_slot;
  logic [IDXW-1:0]         newest_slot;
  logic [IDXW-1:0]         cur_next;
  logic [IDXW-1:0]         scan_next;
  logic                    full;
  logic                    issue, match, last_miss;

  // ring arithmetic: oldest slot, newest slot, single-step wraps
  always_comb begin
    start_sum   = (CNTW+1)'(cur_q) + (CNTW+1)'(DEPTH) - (CNTW+1)'(cnt_q);
    start_slot  = (start_sum >= (CNTW+1)'(DEPTH)) ? IDXW'(start_sum - (CNTW+1)'(DEPTH))
                                                  : IDXW'(start_sum);
    newest_slot = (cur_q == '0) ? IDXW'(DEPTH - 1) : cur_q - 1'b1;
    cur_next    = (cur_q == IDXW'(DEPTH - 1)) ? '0 : cur_q + 1'b1;
    scan_next   = (scan_slot_q == IDXW'(DEPTH - 1)) ? '0 : scan_slot_q + 1'b1;
    full        = (cnt_q == CNTW'(DEPTH));
    issue       = (scan_ofs_q < cnt_q);
    match       = rd_vld_q && (key_rd_q == op_hdr_q.key);
    last_miss   = rd_vld_q && rd_last_q;
  end

  // sequencer: next state, memory port control and result staging
  always_comb begin
    st_d         = st_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    op_ld        = 1'b0;
    pop_o        = 1'b0;
    scan_ofs_d   = scan_ofs_q;
    scan_slot_d  = scan_slot_q;
    rd_addr      = scan_slot_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    rd_slot_d    = scan_slot_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_evict_d  = res_evict_q;
    key_we       = 1'b0;
    pt_we        = 1'b0;
    wr_addr      = hit_q;
    wr_key       = key_rd_q;
    wr_pay       = pay_rd_q;
    wr_time      = time_rd_q;
    out_ld       = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o       = 1'b1;
          op_ld       = 1'b1;
          res_slot_d  = '0;
          res_evict_d = '0;
          if (pop_hdr_i.cmd == CMD_REMOVE && cnt_q == '0) begin
            res_status_d = RES_EMPTY;
            st_d         = S_EMIT;
          end else if (cnt_q == '0) begin
            st_d = S_MISS;
          end else begin
            scan_ofs_d  = '0;
            scan_slot_d = start_slot;
            st_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_d = rd_slot_q;
          st_d  = S_HIT;
        end else if (last_miss) begin
          if (op_hdr_q.cmd == CMD_REMOVE) begin
            res_status_d = RES_NOT_FOUND;
            st_d         = S_EMIT;
          end else begin
            st_d = S_MISS;
          end
        end else if (issue) begin
          rd_vld_d    = 1'b1;
          rd_last_d   = (scan_ofs_q == cnt_q - 1'b1);
          rd_slot_d   = scan_slot_q;
          scan_ofs_d  = scan_ofs_q + 1'b1;
          scan_slot_d = scan_next;
        end
      end
      S_HIT: begin
        if (op_hdr_q.cmd == CMD_INSERT) begin
          pt_we        = 1'b1;
          wr_addr      = hit_q;
          wr_pay       = op_pay_q;
          wr_time      = op_hdr_q.stamp;
          res_status_d = RES_UPDATED;
          res_slot_d   = hit_q;
          st_d         = S_EMIT;
        end else begin
          rd_addr = newest_slot;
          st_d    = S_COPY;
        end
      end
      S_COPY: begin
        // newest entry moves into the freed slot
        key_we       = 1'b1;
        pt_we        = 1'b1;
        wr_addr      = hit_q;
        cur_d        = newest_slot;
        cnt_d        = cnt_q - 1'b1;
        res_status_d = RES_REMOVED;
        res_slot_d   = hit_q;
        st_d         = S_EMIT;
      end
      S_MISS: begin
        rd_addr = cur_q;
        st_d    = S_FILL;
      end
      S_FILL: begin
        key_we       = 1'b1;
        pt_we        = 1'b1;
        wr_addr      = cur_q;
        wr_key       = op_hdr_q.key;
        wr_pay       = op_pay_q;
        wr_time      = op_hdr_q.stamp;
        res_slot_d   = cur_q;
        res_evict_d  = full ? key_rd_q : '0;
        res_status_d = full ? RES_EVICTED : RES_INSERTED;
        cur_d        = cur_next;
        cnt_d        = full ? cnt_q : cnt_q + 1'b1;
        st_d         = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_ld = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cur_q    <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // operation and scan datapath registers
  always_ff @(posedge clk_i) begin
    if (op_ld) begin
      op_hdr_q <= pop_hdr_i;
      op_pay_q <= pop_payload_i;
    end
    scan_ofs_q   <= scan_ofs_d;
    scan_slot_q  <= scan_slot_d;
    rd_last_q    <= rd_last_d;
    rd_slot_q    <= rd_slot_d;
    hit_q        <= hit_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_evict_q  <= res_evict_d;
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (pt_we) begin
      pay_mem[wr_addr]  <= wr_pay;
      time_mem[wr_addr] <= wr_time;
    end
    key_rd_q  <= key_mem[rd_addr];
    pay_rd_q  <= pay_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
  end

  // output register, freed by a transfer
  assign out_vld_d = out_ld || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_cnt_q    <= cnt_q;
      out_evict_q  <= res_evict_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_slot_q;
  assign entry_count_o = out_cnt_q;
  assign evicted_key_o = out_evict_q;

  // checks
  `KRT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNTW'(DEPTH), "live count above depth")
  `KRT_ASSERT_NOW(a_scan_nonempty, st_q == S_SCAN, cnt_q != '0, "scan on empty ring")
  `KRT_ASSERT_NOW(a_copy_remove, st_q == S_COPY, op_hdr_q.cmd == CMD_REMOVE,
                  "copy step outside a remove")
  `KRT_ASSERT_NEXT(a_out_load, out_ld, out_vld_q, "result load lost")

endmodule

// ===== sv/keyed_ring_table_unit.sv =====
// top level of the keyed ring table: front stage, queue and table engine
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------------
//  in      | in_valid_i  | in_stall_o  | command_i entry_key_i entry_payload_i entry_time_i
//  out     | out_valid_o | out_stall_i | status_o slot_index_o entry_count_o evicted_key_o
//
// an item's time in the engine is shortest for a remove on an empty ring and longest
// for an insert on a full ring with no hit, set by the key scan: one slot read per entry
// the front stage register and the queue hold up to three further items
// reset clears cursor, count and all handshake state; slot memories are not cleared
// a stalled result holds the engine in its final step while front and queue fill up
module keyed_ring_table_unit #(
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [krt_pkg::KeyW-1:0]     entry_key_i,
  input  logic [krt_pkg::PayloadW-1:0] entry_payload_i,
  input  logic [krt_pkg::TimeW-1:0]    entry_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output krt_pkg::krt_status_e         status_o,
  output logic [$clog2(DEPTH)-1:0]     slot_index_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_count_o,
  output logic [krt_pkg::KeyW-1:0]     evicted_key_o
);
  import krt_pkg::*;

  localparam int QW = $bits(krt_hdr_t) + PAYLOAD_BITS;

  krt_qstat_t              q_stat;
  logic                    push, pop;
  krt_hdr_t                push_hdr, pop_hdr;
  logic [PAYLOAD_BITS-1:0] push_pay, pop_pay;
  logic [QW-1:0]           pop_data;

  // input side
  krt_front #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .entry_key_i    (entry_key_i),
    .entry_payload_i(entry_payload_i),
    .entry_time_i   (entry_time_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_hdr_o     (push_hdr),
    .push_payload_o (push_pay)
  );

  // decoupling queue
  krt_queue #(
    .W(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_hdr, push_pay}),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  assign pop_hdr = krt_hdr_t'(pop_data[QW-1:PAYLOAD_BITS]);
  assign pop_pay = pop_data[PAYLOAD_BITS-1:0];

  // table engine
  krt_engine #(
    .DEPTH       (DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .pop_hdr_i    (pop_hdr),
    .pop_payload_i(pop_pay),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .entry_count_o(entry_count_o),
    .evicted_key_o(evicted_key_o)
  );

endmodule

// ===== tb/tb_keyed_ring_table_unit.sv =====
// self-checking testbench for the keyed ring table unit
`timescale 1ns / 100ps

module tb_keyed_ring_table_unit;
  import krt_pkg::*;

  localparam int    Depth       = 32;
  localparam int    SlotW       = $clog2(Depth);
  localparam int    CountW      = $clog2(Depth + 1);
  localparam time   ClkPeriod   = 8ns;
  localparam int    ResetCycles = 6;
  localparam int    PoolSize    = 40;
  localparam int    RandomItems = 1250;
  localparam int    QuietTail   = 150;
  localparam int    CycleLimit  = 500000;

  // one table operation as presented on the input channel
  typedef struct {
    krt_cmd_e             cmd;
    logic [KeyW-1:0]      key;
    logic [PayloadW-1:0]  payload;
    logic [TimeW-1:0]     stamp;
  } table_op_t;

  // one table response as seen on the output channel
  typedef struct {
    krt_status_e          status;
    logic [SlotW-1:0]     slot;
    logic [CountW-1:0]    count;
    logic [KeyW-1:0]      evicted;
  } table_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  krt_cmd_e              in_cmd = CMD_INSERT;
  logic [KeyW-1:0]       in_key = '0;
  logic [PayloadW-1:0]   in_payload = '0;
  logic [TimeW-1:0]      in_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  krt_status_e           out_status;
  logic [SlotW-1:0]      out_slot;
  logic [CountW-1:0]     out_count;
  logic [KeyW-1:0]       out_evicted;

  // shadow copy of the table contents
  logic [KeyW-1:0]       ring_keys     [Depth];
  logic [PayloadW-1:0]   ring_payloads [Depth];
  logic [TimeW-1:0]      ring_times    [Depth];
  logic [SlotW-1:0]      ring_cursor = '0;
  logic [CountW-1:0]     ring_count = '0;

  table_op_t             pending_ops[$];
  table_res_t            expected_results[$];
  logic [KeyW-1:0]       key_pool[PoolSize];
  int                    gap_left = 0;
  int                    stall_left = 0;
  int                    cycle_count = 0;
  int                    mismatches = 0;
  int                    status_seen[6] = '{default: 0};

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  keyed_ring_table_unit #(
    .DEPTH        (Depth),
    .PAYLOAD_BITS (PayloadW)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (in_cmd),
    .entry_key_i     (in_key),
    .entry_payload_i (in_payload),
    .entry_time_i    (in_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (out_status),
    .slot_index_o    (out_slot),
    .entry_count_o   (out_count),
    .evicted_key_o   (out_evicted)
  );

  // apply one operation to the shadow table and return the response it gives
  function automatic table_res_t apply_table_op(table_op_t op);
    table_res_t r;
    int         oldest;
    int         s;
    int         hit;
    int         newest;
    r.status  = RES_NOT_FOUND;
    r.slot    = '0;
    r.evicted = '0;
    hit       = -1;
    // search the live window from oldest to newest
    oldest = (int'(ring_cursor) + Depth - int'(ring_count)) % Depth;
    for (int i = 0; i < int'(ring_count); i++) begin
      s = (oldest + i) % Depth;
      if (hit < 0 && ring_keys[s] == op.key) hit = s;
    end
    if (op.cmd == CMD_INSERT) begin
      if (hit >= 0) begin
        ring_payloads[hit] = op.payload;
        ring_times[hit]    = op.stamp;
        r.slot             = SlotW'(hit);
        r.status           = RES_UPDATED;
      end else begin
        // new entry at the cursor, overwriting the oldest one when full
        r.slot = ring_cursor;
        if (int'(ring_count) >= Depth) begin
          r.evicted = ring_keys[ring_cursor];
          r.status  = RES_EVICTED;
        end else begin
          r.status = RES_INSERTED;
        end
        ring_keys[ring_cursor]     = op.key;
        ring_payloads[ring_cursor] = op.payload;
        ring_times[ring_cursor]    = op.stamp;
        ring_cursor = SlotW'((int'(ring_cursor) + 1) % Depth);
        if (int'(ring_count) < Depth) ring_count = ring_count + 1'b1;
      end
    end else if (ring_count == '0) begin
      r.status = RES_EMPTY;
    end else if (hit >= 0) begin
      // newest entry fills the hole, window shrinks from the newest end
      newest              = (int'(ring_cursor) + Depth - 1) % Depth;
      ring_keys[hit]      = ring_keys[newest];
      ring_payloads[hit]  = ring_payloads[newest];
      ring_times[hit]     = ring_times[newest];
      ring_cursor         = SlotW'(newest);
      ring_count          = ring_count - 1'b1;
      r.slot              = SlotW'(hit);
      r.status            = RES_REMOVED;
    end
    r.count = ring_count;
    return r;
  endfunction

  // queue an operation with random payload and timestamp
  function automatic void push_op(krt_cmd_e cmd, logic [KeyW-1:0] key);
    table_op_t op;
    op.cmd     = cmd;
    op.key     = key;
    op.payload = {$urandom, $urandom};
    op.stamp   = $urandom;
    pending_ops.push_back(op);
  endfunction

  // mixed traffic on the key pool, with the odd remove of an unknown key
  function automatic void push_mixed(int n, int insert_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        push_op(CMD_INSERT, key_pool[$urandom_range(0, PoolSize - 1)]);
      end else if ($urandom_range(0, 3) == 0) begin
        push_op(CMD_REMOVE, $urandom);
      end else begin
        push_op(CMD_REMOVE, key_pool[$urandom_range(0, PoolSize - 1)]);
      end
    end
  endfunction

  // input driver: presents queued operations, predicts on each transfer
  always @(posedge clk_i) begin : drive_proc
    table_op_t  op;
    table_res_t res;
    logic       quiet;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        op.cmd     = in_cmd;
        op.key     = in_key;
        op.payload = in_payload;
        op.stamp   = in_time;
        res        = apply_table_op(op);
        status_seen[int'(res.status)]++;
        expected_results.push_back(res);
      end
      quiet = (pending_ops.size() < QuietTail) || ((cycle_count / 3000) % 4 == 1);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          // start an idle burst
          gap_left <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op          = pending_ops.pop_front();
          in_cmd     <= op.cmd;
          in_key     <= op.key;
          in_payload <= op.payload;
          in_time    <= op.stamp;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each transfer against the oldest expectation
  always @(posedge clk_i) begin : monitor_proc
    table_res_t want;
    logic       quiet;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected response status %0d slot %0d count %0d evicted %h",
                   $time, out_status, out_slot, out_count, out_evicted);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatches++;
          end
          if (out_slot !== want.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, out_slot);
            mismatches++;
          end
          if (out_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count, out_count);
            mismatches++;
          end
          if (out_evicted !== want.evicted) begin
            $display("%0t: evicted_key expected %h actual %h", $time, want.evicted,
                     out_evicted);
            mismatches++;
          end
        end
      end
      quiet = (pending_ops.size() < QuietTail) || ((cycle_count / 3000) % 4 == 3);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin : watchdog_proc
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("%0t: timeout, %0d responses outstanding", $time, expected_results.size());
    $display("tb_keyed_ring_table_unit: FAIL");
    $finish;
  end

  // stimulus build, reset and end of run
  initial begin : run_proc
    int off;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;

    // directed: empty ring, key and field extremes, update, misses, all remove positions
    push_op(CMD_REMOVE, 32'h0000_0000);
    pending_ops.push_back('{CMD_INSERT, 32'h0000_0000, 64'h0, 32'h0});
    pending_ops.push_back('{CMD_INSERT, 32'hFFFF_FFFF, '1, '1});
    pending_ops.push_back('{CMD_INSERT, 32'h0000_0000, 64'h5555_5555_5555_5555,
                            32'hAAAA_AAAA});
    push_op(CMD_REMOVE, 32'h1234_5678);
    push_op(CMD_INSERT, 32'hA5A5_A5A5);
    push_op(CMD_INSERT, 32'h5A5A_5A5A);
    push_op(CMD_REMOVE, 32'hFFFF_FFFF);
    push_op(CMD_REMOVE, 32'hA5A5_A5A5);
    push_op(CMD_REMOVE, 32'h0000_0000);
    push_op(CMD_REMOVE, 32'hFFFF_FFFF);
    push_op(CMD_REMOVE, 32'h5A5A_5A5A);
    push_op(CMD_REMOVE, 32'h5A5A_5A5A);

    // random: fill past capacity, churn, then drain the whole pool to empty
    while (pending_ops.size() < RandomItems) begin
      push_mixed(50, 85);
      push_mixed(50, 55);
      off = $urandom_range(0, PoolSize - 1);
      for (int i = 0; i < PoolSize; i++) push_op(CMD_REMOVE, key_pool[(off + i) % PoolSize]);
      push_op(CMD_REMOVE, key_pool[off]);
      push_op(CMD_REMOVE, $urandom);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (Depth + 10) @(posedge clk_i);

    $display("operations checked: updated %0d, inserted %0d, evicted %0d, removed %0d",
             status_seen[RES_UPDATED], status_seen[RES_INSERTED],
             status_seen[RES_EVICTED], status_seen[RES_REMOVED]);
    $display("misses on remove %0d, removes on empty ring %0d, mismatches %0d",
             status_seen[RES_NOT_FOUND], status_seen[RES_EMPTY], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_keyed_ring_table_unit: PASS");
    end else begin
      $display("tb_keyed_ring_table_unit: FAIL");
    end
    $finish;
  end

endmodule
